// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the checker file tts_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== hw/rtl/tts_pkg.sv =====
`default_nettype none

package tts_pkg;

   typedef enum logic [2:0] {
      PH_HDR  = 3'd0,
      PH_TAG  = 3'd1,
      PH_LEN0 = 3'd2,
      PH_LEN1 = 3'd3,
      PH_SKIP = 3'd4,
      PH_CAP  = 3'd5,
      PH_DONE = 3'd6
   } phase_type;

   typedef enum logic [2:0] {
      ST_OK         = 3'd0,
      ST_SHORT      = 3'd1,
      ST_CUT_HDR    = 3'd2,
      ST_CUT_VAL    = 3'd3,
      ST_ABSENT     = 3'd4,
      ST_BAD_LEN    = 3'd5,
      ST_NOT_FINITE = 3'd6
   } status_type;

   localparam logic [2:0] KIND_U8  = 3'd1;
   localparam logic [2:0] KIND_U16 = 3'd2;
   localparam logic [2:0] KIND_I16 = 3'd3;
   localparam logic [2:0] KIND_I32 = 3'd4;
   localparam logic [2:0] KIND_F32 = 3'd5;

   localparam logic CSR_WANTED_TAG = 1'b0;
   localparam logic CSR_VALUE_KIND = 1'b1;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic        found;
      status_type  status;
      logic [15:0] value_offset;
      logic [15:0] value_length;
      logic [31:0] value_bits;
   } rsp_type;

endpackage

`default_nettype wire

// ===== hw/rtl/tlv_tag_search.sv =====
`default_nettype none

// Channel  Direction  Handshake          Beat
// req      in         req_valid/stall    one body byte with last-byte mark
// rsp      out        rsp_valid/stall    one search result per body
// csr      in         csr_valid/ready    register index and write data
//
// The block takes one byte per unstalled cycle; the parser state updates in that cycle.
// A result is registered on the cycle the last byte is taken and shows in the next cycle.
// Input stalls only while a result is held and the result side stalls.
// Synchronous reset clears the parser state, the CSR registers and the result valid.

module tlv_tag_search #(
   parameter int HEADER_BYTES   = 8,
   parameter int MAX_BODY_BYTES = 65536
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output      logic            req_stall,
   input  wire tts_pkg::req_type req_data,
   output      logic            rsp_valid,
   input  wire logic            rsp_stall,
   output      tts_pkg::rsp_type rsp_data,
   input  wire logic            csr_valid,
   output      logic            csr_ready,
   input  wire logic            csr_index,
   input  wire logic [7:0]      csr_wdata
);

   localparam int POS_W = $clog2(MAX_BODY_BYTES);
   localparam int HDR_W = (POS_W + 1 > 9) ? POS_W + 1 : 9;
   localparam tts_pkg::phase_type START_PHASE =
      (HEADER_BYTES > 0) ? tts_pkg::PH_HDR : tts_pkg::PH_TAG;

   tts_pkg::phase_type phase_ff, phase_in;
   logic [POS_W-1:0]   pos_ff, pos_in;
   logic [15:0]        remain_ff, remain_in;
   logic [7:0]         tag_ff, tag_in;
   logic [15:0]        length_ff, length_in;
   logic [POS_W-1:0]   offset_ff, offset_in;
   logic [31:0]        capture_ff, capture_in;
   logic               settled_ff, settled_in;
   logic [7:0]         wanted_tag_ff;
   logic [2:0]         value_kind_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   tts_pkg::rsp_type   rsp_data_ff, rsp_data_in;

   logic               req_accept;
   logic               rsp_load;
   logic [POS_W:0]     pos_inc;
   logic [POS_W-1:0]   pos_next;
   logic               hdr_end;
   logic [15:0]        length_full;
   logic [15:0]        cap_index;
   logic [7:0]         in_byte;
   logic [15:0]        need;
   logic [31:0]        bits;

   assign in_byte     = req_data.data_byte;
   assign req_stall   = rsp_valid_ff && rsp_stall;
   assign req_accept  = req_valid && !req_stall;
   assign rsp_load    = req_accept && req_data.last_byte;
   assign csr_ready   = 1'b1;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_data    = rsp_data_ff;

   assign pos_inc     = {1'b0, pos_ff} + (POS_W + 1)'(1);
   assign pos_next    = (pos_inc == (POS_W + 1)'(MAX_BODY_BYTES)) ? '0 : pos_inc[POS_W-1:0];
   assign hdr_end     = HDR_W'(pos_inc) >= HDR_W'(HEADER_BYTES);
   assign length_full = {in_byte, length_ff[7:0]};
   assign cap_index   = length_ff - remain_ff;

   always_comb begin
      phase_in = phase_ff;
      unique case (phase_ff)
         tts_pkg::PH_HDR: begin
            if (hdr_end) begin
               phase_in = tts_pkg::PH_TAG;
            end
         end
         tts_pkg::PH_TAG:  phase_in = tts_pkg::PH_LEN0;
         tts_pkg::PH_LEN0: phase_in = tts_pkg::PH_LEN1;
         tts_pkg::PH_LEN1: begin
            if (tag_ff == wanted_tag_ff) begin
               phase_in = (length_full == 16'd0) ? tts_pkg::PH_DONE : tts_pkg::PH_CAP;
            end else begin
               phase_in = (length_full == 16'd0) ? tts_pkg::PH_TAG : tts_pkg::PH_SKIP;
            end
         end
         tts_pkg::PH_SKIP: begin
            if (remain_ff == 16'd1) begin
               phase_in = tts_pkg::PH_TAG;
            end
         end
         tts_pkg::PH_CAP: begin
            if (remain_ff == 16'd1) begin
               phase_in = tts_pkg::PH_DONE;
            end
         end
         default: phase_in = phase_ff;
      endcase
   end

   always_comb begin
      tag_in     = tag_ff;
      length_in  = length_ff;
      remain_in  = remain_ff;
      offset_in  = offset_ff;
      capture_in = capture_ff;
      settled_in = settled_ff;
      unique case (phase_ff)
         tts_pkg::PH_TAG:  tag_in = in_byte;
         tts_pkg::PH_LEN0: length_in = {8'd0, in_byte};
         tts_pkg::PH_LEN1: begin
            length_in = length_full;
            if (tag_ff == wanted_tag_ff) begin
               offset_in  = pos_next;
               capture_in = 32'd0;
               if (length_full == 16'd0) begin
                  settled_in = 1'b1;
               end else begin
                  remain_in = length_full;
               end
            end else if (length_full != 16'd0) begin
               remain_in = length_full;
            end
         end
         tts_pkg::PH_SKIP: remain_in = remain_ff - 16'd1;
         tts_pkg::PH_CAP: begin
            if (cap_index < 16'd4) begin
               capture_in = capture_ff | (32'(in_byte) << {cap_index[1:0], 3'b000});
            end
            remain_in = remain_ff - 16'd1;
            if (remain_ff == 16'd1) begin
               settled_in = 1'b1;
            end
         end
         default: tag_in = tag_ff;
      endcase
   end

   always_comb begin
      need = 16'd0;
      bits = 32'd0;
      unique case (value_kind_ff) inside
         tts_pkg::KIND_U8: begin
            need = 16'd1;
            bits = {24'd0, capture_in[7:0]};
         end
         tts_pkg::KIND_U16: begin
            need = 16'd2;
            bits = {16'd0, capture_in[15:0]};
         end
         tts_pkg::KIND_I16: begin
            need = 16'd2;
            bits = {{16{capture_in[15]}}, capture_in[15:0]};
         end
         tts_pkg::KIND_I32, tts_pkg::KIND_F32: begin
            need = 16'd4;
            bits = capture_in;
         end
         default: begin
            need = 16'd0;
            bits = 32'd0;
         end
      endcase

      rsp_data_in = '{found: 1'b0, status: tts_pkg::ST_OK, value_offset: 16'd0,
                      value_length: 16'd0, value_bits: 32'd0};
      if (phase_in == tts_pkg::PH_HDR) begin
         rsp_data_in.status = tts_pkg::ST_SHORT;
      end else if (phase_in == tts_pkg::PH_TAG) begin
         rsp_data_in.status = tts_pkg::ST_ABSENT;
      end else if (phase_in == tts_pkg::PH_LEN0 || phase_in == tts_pkg::PH_LEN1) begin
         rsp_data_in.status = tts_pkg::ST_CUT_HDR;
      end else if (phase_in == tts_pkg::PH_SKIP || phase_in == tts_pkg::PH_CAP
                   || !settled_in) begin
         rsp_data_in.status = tts_pkg::ST_CUT_VAL;
      end else begin
         rsp_data_in.value_offset = 16'(offset_in);
         rsp_data_in.value_length = length_in;
         if (need != 16'd0 && length_in != need) begin
            rsp_data_in.status = tts_pkg::ST_BAD_LEN;
         end else if (value_kind_ff == tts_pkg::KIND_F32 && bits[30:23] == 8'hFF) begin
            rsp_data_in.status = tts_pkg::ST_NOT_FINITE;
         end else begin
            rsp_data_in.found      = 1'b1;
            rsp_data_in.value_bits = bits;
         end
      end
   end

   always_comb begin
      pos_in = pos_next;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= START_PHASE;
         pos_ff     <= '0;
         remain_ff  <= 16'd0;
         tag_ff     <= 8'd0;
         length_ff  <= 16'd0;
         offset_ff  <= '0;
         capture_ff <= 32'd0;
         settled_ff <= 1'b0;
      end else if (rsp_load) begin
         phase_ff   <= START_PHASE;
         pos_ff     <= '0;
         remain_ff  <= 16'd0;
         tag_ff     <= 8'd0;
         length_ff  <= 16'd0;
         offset_ff  <= '0;
         capture_ff <= 32'd0;
         settled_ff <= 1'b0;
      end else if (req_accept) begin
         phase_ff   <= phase_in;
         pos_ff     <= pos_in;
         remain_ff  <= remain_in;
         tag_ff     <= tag_in;
         length_ff  <= length_in;
         offset_ff  <= offset_in;
         capture_ff <= capture_in;
         settled_ff <= settled_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wanted_tag_ff <= 8'd0;
         value_kind_ff <= 3'd0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            tts_pkg::CSR_WANTED_TAG: wanted_tag_ff <= csr_wdata;
            tts_pkg::CSR_VALUE_KIND: value_kind_ff <= csr_wdata[2:0];
            default: wanted_tag_ff <= wanted_tag_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/tts_checker.sv =====
`default_nettype none

`include "assert_macros.svh"

module tts_checker (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             req_valid,
   input wire logic             req_stall,
   input wire tts_pkg::req_type req_data,
   input wire logic             rsp_valid,
   input wire logic             rsp_stall,
   input wire tts_pkg::rsp_type rsp_data
);

   logic rsp_held;
   logic last_taken;
   logic early_status;
   logic found_ok;
   logic fields_zero;

   assign rsp_held     = rsp_valid && rsp_stall;
   assign last_taken   = req_valid && !req_stall && req_data.last_byte;
   assign early_status = rsp_data.status == tts_pkg::ST_SHORT
                         || rsp_data.status == tts_pkg::ST_CUT_HDR
                         || rsp_data.status == tts_pkg::ST_CUT_VAL
                         || rsp_data.status == tts_pkg::ST_ABSENT;
   assign found_ok     = rsp_data.found == (rsp_data.status == tts_pkg::ST_OK);
   assign fields_zero  = rsp_data.value_offset == 16'd0
                         && rsp_data.value_length == 16'd0
                         && rsp_data.value_bits == 32'd0;

   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_held, rsp_valid && $stable(rsp_data))
   `ASSERT_SAME(a_found_ok, clock, reset, rsp_valid, found_ok)
   `ASSERT_SAME(a_early_zero, clock, reset, rsp_valid && early_status, fields_zero)
   `ASSERT_SAME(a_new_rsp_cause, clock, reset, rsp_valid && !$past(rsp_held), $past(last_taken))

endmodule

bind tlv_tag_search tts_checker u_tts_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

`default_nettype wire
